>>> rtl/fmtint_pkg.sv
// Shared constants, types and helpers for the integer formatter core.
// Used by fmtint_digit_unit and format_string_integer_formatter_core.
// Has no dependencies of its own.
package fmtint_pkg;

  // Character codes used by the format parser and the digit emitter.
  localparam logic [7:0] CHAR_PERCENT = 8'h25;  // '%'
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;  // '-'
  localparam logic [7:0] CHAR_ZERO    = 8'h30;  // '0'
  localparam logic [7:0] CHAR_UC_A    = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_LC_C    = 8'h63;  // 'c'
  localparam logic [7:0] CHAR_LC_D    = 8'h64;  // 'd'
  localparam logic [7:0] CHAR_LC_O    = 8'h6F;  // 'o'
  localparam logic [7:0] CHAR_LC_X    = 8'h78;  // 'x'

  // At most this many characters are produced by one item.
  localparam int unsigned MAX_RESULTS = 12;
  localparam int unsigned NOUT_W      = 4;

  // Operations of the shared digit unit.
  typedef enum logic [2:0] {
    DU_HOLD,
    DU_LOAD_BIN,
    DU_LOAD_HEX,
    DU_LOAD_OCT,
    DU_DABBLE,
    DU_SHIFT
  } du_op_t;

  typedef struct packed {
    du_op_t op;
  } du_ctrl_t;

  // Maps a digit value 0..15 to its uppercase ASCII character.
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] dx;
    dx = {4'b0000, d};
    if (d > 4'd9) begin
      digit_char = CHAR_UC_A + dx - 8'd10;
    end else begin
      digit_char = CHAR_ZERO + dx;
    end
  endfunction

endpackage

>>> rtl/fmtint_digit_unit.sv
// Shared digit unit: holds the magnitude and its digit register, and runs
// one shift-add-3 step, a load or a digit shift per cycle.
// Depends on fmtint_pkg.
module fmtint_digit_unit #(
  parameter int ARG_WIDTH = 32
) (
  input  logic                  clk,
  input  fmtint_pkg::du_ctrl_t  ctrl,
  input  logic [ARG_WIDTH-1:0]  mag,
  output logic [3:0]            top_digit
);
  import fmtint_pkg::*;

  // Octal needs the most digits of the three bases.
  localparam int NDIG  = (ARG_WIDTH + 2) / 3;
  localparam int DIG_W = 4 * NDIG;
  localparam int OCT_W = 3 * NDIG;

  logic [ARG_WIDTH-1:0] bin_r, bin_nxt;
  logic [DIG_W-1:0]     dig_r, dig_nxt;
  logic [DIG_W-1:0]     adj;
  logic [DIG_W-1:0]     oct_dig;
  logic [OCT_W-1:0]     mag_oct;

  // Add 3 to every BCD digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (dig_r[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = dig_r[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = dig_r[4*i +: 4];
      end
    end
  end

  // Spread the 3-bit octal groups into nibbles.
  assign mag_oct = OCT_W'(mag);
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      oct_dig[4*i +: 4] = {1'b0, mag_oct[3*i +: 3]};
    end
  end

  always_comb begin
    bin_nxt = bin_r;
    dig_nxt = dig_r;
    case (ctrl.op)
      DU_HOLD: begin
      end
      DU_LOAD_BIN: begin
        bin_nxt = mag;
        dig_nxt = '0;
      end
      DU_LOAD_HEX: begin
        dig_nxt = DIG_W'(mag);
      end
      DU_LOAD_OCT: begin
        dig_nxt = oct_dig;
      end
      DU_DABBLE: begin
        dig_nxt = {adj[DIG_W-2:0], bin_r[ARG_WIDTH-1]};
        bin_nxt = {bin_r[ARG_WIDTH-2:0], 1'b0};
      end
      DU_SHIFT: begin
        dig_nxt = {dig_r[DIG_W-5:0], 4'b0000};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    dig_r <= dig_nxt;
  end

  assign top_digit = dig_r[DIG_W-1 -: 4];

endmodule

>>> rtl/format_string_integer_formatter_core.sv
// Top level of the integer formatter: format-string parser, sequencer and
// output register around the shared digit unit.
// Depends on fmtint_pkg and fmtint_digit_unit.
//
// This core takes one format character per input item and writes the
// formatted text one character per output item, with out_tlast marking
// the final character that an input item causes. Ordinary characters are
// copied; '%' emits nothing and arms a conversion; the next character picks
// 'c' (low byte of the argument), 'd' (signed decimal), 'x' (signed
// uppercase hex) or 'o' (signed octal), and any other letter emits nothing.
// Numbers come most significant digit first with a leading '-' when
// negative, zero is written as "0", and at most twelve characters are
// written per item (the limit can cut a number short only when ARG_WIDTH
// is above 32). The core works on one item at a time and in_tready is low
// while an item is in progress. Hex and octal load the digit register,
// drop the leading zero digits of the padded register (ceil(ARG_WIDTH/3)
// digits) and then write one character per step. Decimal first runs
// ARG_WIDTH shift-add-3 steps through the shared digit unit, then follows
// the same leading-zero and emit steps. Skipped and written digits add up
// to the register's digit count unless the twelve-character limit cuts a
// number short. Every emitting step waits for the output register to be
// free, so a stalled consumer holds the core in its current step.
module format_string_integer_formatter_core #(
  parameter int ARG_WIDTH = 32
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  // Fields from bit 0 up: fmt_char[7:0], arg_value[ARG_WIDTH-1:0], zero pad.
  input  logic [((8 + ARG_WIDTH + 7) / 8) * 8-1:0] in_tdata,
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  // Fields from bit 0 up: out_char[7:0].
  output logic [7:0]                               out_tdata,
  output logic                                     out_tlast
);
  import fmtint_pkg::*;

  // Number of nibbles in the digit register, and the counter width that
  // covers both the shift-add-3 bit count and the digit count.
  localparam int NDIG = (ARG_WIDTH + 2) / 3;
  localparam int CW   = $clog2(ARG_WIDTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGS
  } state_t;

  state_t              state_r, state_nxt;
  logic                pend_r, pend_nxt;
  logic                neg_r, neg_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [NOUT_W-1:0]   nout_r, nout_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_char_r, out_char_nxt;
  logic                out_last_r, out_last_nxt;

  logic [7:0]           fmt_char;
  logic [ARG_WIDTH-1:0] arg_value;
  logic [ARG_WIDTH-1:0] mag;
  logic                 slot_free;
  logic                 in_fire;
  logic                 last_digit;
  logic [3:0]           top_digit;
  du_ctrl_t             du_ctrl;

  assign fmt_char  = in_tdata[7:0];
  assign arg_value = in_tdata[8 +: ARG_WIDTH];

  // The most negative value negates to itself, which read unsigned is
  // exactly its magnitude.
  assign mag = arg_value[ARG_WIDTH-1] ? ARG_WIDTH'(~arg_value + 1'b1) : arg_value;

  // The output register can take a new character when it is empty or its
  // current character leaves in this cycle.
  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && slot_free;
  assign in_fire   = in_tvalid && in_tready;

  assign last_digit = (cnt_r == CW'(1)) || (nout_r == NOUT_W'(MAX_RESULTS - 1));

  fmtint_digit_unit #(
    .ARG_WIDTH (ARG_WIDTH)
  ) u_digit (
    .clk       (clk),
    .ctrl      (du_ctrl),
    .mag       (mag),
    .top_digit (top_digit)
  );

  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = pend_r;
    neg_nxt       = neg_r;
    cnt_nxt       = cnt_r;
    nout_nxt      = nout_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    du_ctrl.op    = DU_HOLD;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          nout_nxt = '0;
          neg_nxt  = arg_value[ARG_WIDTH-1];
          if (pend_r) begin
            pend_nxt = 1'b0;
            case (fmt_char)
              CHAR_LC_C: begin
                out_valid_nxt = 1'b1;
                out_char_nxt  = arg_value[7:0];
                out_last_nxt  = 1'b1;
              end
              CHAR_LC_D: begin
                du_ctrl.op = DU_LOAD_BIN;
                cnt_nxt    = CW'(ARG_WIDTH);
                state_nxt  = ST_CONV;
              end
              CHAR_LC_X: begin
                du_ctrl.op = DU_LOAD_HEX;
                cnt_nxt    = CW'(NDIG);
                state_nxt  = ST_SKIP;
              end
              CHAR_LC_O: begin
                du_ctrl.op = DU_LOAD_OCT;
                cnt_nxt    = CW'(NDIG);
                state_nxt  = ST_SKIP;
              end
              default: begin
              end
            endcase
          end else if (fmt_char == CHAR_PERCENT) begin
            pend_nxt = 1'b1;
          end else begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = fmt_char;
            out_last_nxt  = 1'b1;
          end
        end
      end
      // One shift-add-3 step per cycle turns the magnitude into BCD.
      ST_CONV: begin
        du_ctrl.op = DU_DABBLE;
        cnt_nxt    = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          cnt_nxt   = CW'(NDIG);
          state_nxt = ST_SKIP;
        end
      end
      // Drop leading zero digits, keeping at least one for a zero value.
      ST_SKIP: begin
        if (top_digit == 4'd0 && cnt_r != CW'(1)) begin
          du_ctrl.op = DU_SHIFT;
          cnt_nxt    = cnt_r - CW'(1);
        end else if (neg_r) begin
          state_nxt = ST_SIGN;
        end else begin
          state_nxt = ST_DIGS;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_MINUS;
          out_last_nxt  = 1'b0;
          nout_nxt      = nout_r + NOUT_W'(1);
          state_nxt     = ST_DIGS;
        end
      end
      ST_DIGS: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = digit_char(top_digit);
          out_last_nxt  = last_digit;
          du_ctrl.op    = DU_SHIFT;
          cnt_nxt       = cnt_r - CW'(1);
          nout_nxt      = nout_r + NOUT_W'(1);
          if (last_digit) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    neg_r      <= neg_nxt;
    cnt_r      <= cnt_nxt;
    nout_r     <= nout_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;

endmodule
